// ----- sv/gtne_pkg.sv -----
// ----------------------------------------------------------------------------
// gtne_pkg - shared types and constants of the grid neighbour enumerator
// Field widths, register codes, neighbour offset table and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gtne_pkg;

    localparam int unsigned IDX_W        = 30;
    localparam int unsigned CFG_W        = 11;
    localparam int unsigned ORD_W        = 5;
    localparam int unsigned NSLOT        = 18;
    localparam int unsigned NSLOT_W      = 5;
    localparam int unsigned CFG_ADDR_W   = 2;
    localparam int unsigned CFG_MAX      = (1 << CFG_W) - 1;
    localparam int unsigned AXIS_MAX_DEF = 1024;
    localparam int unsigned SXY_W        = 2 * CFG_W;
    localparam int unsigned DIV_CNT_W    = $clog2(IDX_W + 1);
    localparam int unsigned S_TDATA_W    = ((IDX_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W    = ((IDX_W + ORD_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SIZE_X     = 2'd0,
        REG_SIZE_Y     = 2'd1,
        REG_SIZE_Z     = 2'd2,
        REG_PARITY_REF = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OFF_NONE = 2'b00,
        OFF_POS  = 2'b01,
        OFF_NEG  = 2'b11
    } t_off;

    typedef struct packed {
        t_off dx;
        t_off dy;
        t_off dz;
    } t_nbr_off;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_sel;
        logic take_x;
        logic take_yz;
        logic build_mask;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic last_pick;
    } t_dp_sts;

    // axis neighbours first, then the edge diagonals
    function automatic t_nbr_off slot_off(input logic [NSLOT_W-1:0] slot);
        t_nbr_off o;
        unique case (slot)
            0:       o = '{OFF_NEG,  OFF_NONE, OFF_NONE};
            1:       o = '{OFF_POS,  OFF_NONE, OFF_NONE};
            2:       o = '{OFF_NONE, OFF_NEG,  OFF_NONE};
            3:       o = '{OFF_NONE, OFF_POS,  OFF_NONE};
            4:       o = '{OFF_NONE, OFF_NONE, OFF_NEG};
            5:       o = '{OFF_NONE, OFF_NONE, OFF_POS};
            6:       o = '{OFF_NEG,  OFF_NEG,  OFF_NONE};
            7:       o = '{OFF_NEG,  OFF_POS,  OFF_NONE};
            8:       o = '{OFF_NEG,  OFF_NONE, OFF_NEG};
            9:       o = '{OFF_NEG,  OFF_NONE, OFF_POS};
            10:      o = '{OFF_POS,  OFF_NEG,  OFF_NONE};
            11:      o = '{OFF_POS,  OFF_POS,  OFF_NONE};
            12:      o = '{OFF_POS,  OFF_NONE, OFF_NEG};
            13:      o = '{OFF_POS,  OFF_NONE, OFF_POS};
            14:      o = '{OFF_NONE, OFF_NEG,  OFF_NEG};
            15:      o = '{OFF_NONE, OFF_NEG,  OFF_POS};
            16:      o = '{OFF_NONE, OFF_POS,  OFF_NEG};
            17:      o = '{OFF_NONE, OFF_POS,  OFF_POS};
            default: o = '{OFF_NONE, OFF_NONE, OFF_NONE};
        endcase
        return o;
    endfunction

    function automatic logic [IDX_W-1:0] off_term(input t_off o, input logic [IDX_W-1:0] val);
        logic [IDX_W-1:0] r;
        unique case (o)
            OFF_POS: r = val;
            OFF_NEG: r = '0 - val;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/gtne_divider.sv -----
// ----------------------------------------------------------------------------
// gtne_divider - bit-serial restoring divider
// Divides an index-wide dividend by a size-wide non-zero divisor, one
// quotient bit per cycle; o_done pulses once quotient and remainder are final.
// ----------------------------------------------------------------------------
module gtne_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gtne_pkg::IDX_W-1:0]   i_dividend,
    input  logic [gtne_pkg::CFG_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [gtne_pkg::IDX_W-1:0]   o_quot,
    output logic [gtne_pkg::CFG_W-1:0]   o_rem
);
    import gtne_pkg::*;

    logic [IDX_W-1:0]     r_quo;
    logic [CFG_W-1:0]     r_rem;
    logic [CFG_W-1:0]     r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CFG_W:0]       trial;
    logic [CFG_W:0]       diff;
    logic                 ge;
    logic [CFG_W-1:0]     n_rem;
    logic [IDX_W-1:0]     n_quo;

    always_comb begin
        trial = {r_rem, r_quo[IDX_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
        n_rem = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        n_quo = {r_quo[IDX_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(IDX_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DIV_CNT_W'(1);
            r_busy <= (r_cnt != DIV_CNT_W'(1));
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- sv/gtne_datapath.sv -----
// ----------------------------------------------------------------------------
// gtne_datapath - configuration, index decode and neighbour generation
// Holds the size registers, decodes the vertex index through the shared
// divider, builds the neighbour mask and drives the output register.
// ----------------------------------------------------------------------------
module gtne_datapath #(
    parameter int unsigned AXIS_MAX = gtne_pkg::AXIS_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr,
    input  logic [gtne_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [gtne_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [gtne_pkg::IDX_W-1:0]       i_vertex,
    input  gtne_pkg::t_dp_cmd                i_cmd,
    output gtne_pkg::t_dp_sts                o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [gtne_pkg::IDX_W-1:0]       o_nbr_idx,
    output logic [gtne_pkg::ORD_W-1:0]       o_nbr_ord,
    output logic                             o_is_valid,
    output logic                             o_is_last
);
    import gtne_pkg::*;

    localparam logic [CFG_W-1:0] CLAMP =
        (AXIS_MAX > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(AXIS_MAX);
    localparam int unsigned ZPAD = IDX_W - CFG_W;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] r;
        if (s == '0) begin
            r = CFG_W'(1);
        end else if (s > CLAMP) begin
            r = CLAMP;
        end else begin
            r = s;
        end
        return r;
    endfunction

    logic [CFG_W-1:0]   r_size_x;
    logic [CFG_W-1:0]   r_size_y;
    logic [CFG_W-1:0]   r_size_z;
    logic               r_par;

    logic [IDX_W-1:0]   r_v;
    logic [SXY_W-1:0]   r_sxy;
    logic [CFG_W-1:0]   r_x;
    logic [CFG_W-1:0]   r_y;
    logic [IDX_W-1:0]   r_tz;
    logic [NSLOT-1:0]   r_mask;
    logic [ORD_W-1:0]   r_ord;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [ORD_W-1:0]   r_out_ord;
    logic               r_out_vld;
    logic               r_out_last;

    logic [CFG_W-1:0]   sx;
    logic [CFG_W-1:0]   sy;
    logic [CFG_W-1:0]   sz;
    logic               div_done;
    logic [IDX_W-1:0]   div_quot;
    logic [CFG_W-1:0]   div_rem;
    logic [IDX_W-1:0]   div_dividend;
    logic [CFG_W-1:0]   div_divisor;

    logic               xm, xp, ym, yp, zm, zp, diag;
    logic [NSLOT-1:0]   n_mask;
    logic [NSLOT-1:0]   low;
    logic [NSLOT-1:0]   rest;
    logic [NSLOT_W-1:0] pick;
    t_nbr_off           off;
    logic [IDX_W-1:0]   nbr;

    assign sx = eff_size(r_size_x);
    assign sy = eff_size(r_size_y);
    assign sz = eff_size(r_size_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= CFG_W'(1);
            r_size_y <= CFG_W'(1);
            r_size_z <= CFG_W'(1);
            r_par    <= 1'b1;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_addr)
                REG_SIZE_X:     r_size_x <= i_cfg_data;
                REG_SIZE_Y:     r_size_y <= i_cfg_data;
                REG_SIZE_Z:     r_size_z <= i_cfg_data;
                REG_PARITY_REF: r_par    <= i_cfg_data[0];
                default:        r_par    <= r_par;
            endcase
        end
    end

    assign div_dividend = i_cmd.div_sel ? r_tz : r_v;
    assign div_divisor  = i_cmd.div_sel ? sy : sx;

    gtne_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v   <= i_vertex;
            r_sxy <= SXY_W'(sx) * SXY_W'(sy);
        end
        if (i_cmd.take_x) begin
            r_x  <= div_rem;
            r_tz <= div_quot;
        end
        if (i_cmd.take_yz) begin
            r_y  <= div_rem;
            r_tz <= div_quot;
        end
    end

    // bounds flags; z may lie beyond the grid, so a step down is checked too
    always_comb begin
        xm   = (r_x != '0);
        xp   = (({1'b0, r_x} + (CFG_W+1)'(1)) < {1'b0, sx});
        ym   = (r_y != '0);
        yp   = (({1'b0, r_y} + (CFG_W+1)'(1)) < {1'b0, sy});
        zm   = (r_tz != '0) && (r_tz <= {{ZPAD{1'b0}}, sz});
        zp   = (({1'b0, r_tz} + (IDX_W+1)'(1)) < {{(ZPAD+1){1'b0}}, sz});
        diag = ((r_x[0] ^ r_y[0] ^ r_tz[0]) != r_par);
        n_mask[0]  = xm;
        n_mask[1]  = xp;
        n_mask[2]  = ym;
        n_mask[3]  = yp;
        n_mask[4]  = zm;
        n_mask[5]  = zp;
        n_mask[6]  = diag & xm & ym;
        n_mask[7]  = diag & xm & yp;
        n_mask[8]  = diag & xm & zm;
        n_mask[9]  = diag & xm & zp;
        n_mask[10] = diag & xp & ym;
        n_mask[11] = diag & xp & yp;
        n_mask[12] = diag & xp & zm;
        n_mask[13] = diag & xp & zp;
        n_mask[14] = diag & ym & zm;
        n_mask[15] = diag & ym & zp;
        n_mask[16] = diag & yp & zm;
        n_mask[17] = diag & yp & zp;
    end

    always_comb begin
        low  = r_mask & (~r_mask + NSLOT'(1));
        rest = r_mask & ~low;
        pick = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = NSLOT_W'(i);
            end
        end
        off = slot_off(pick);
        nbr = r_v + off_term(off.dx, IDX_W'(1))
                  + off_term(off.dy, {{ZPAD{1'b0}}, sx})
                  + off_term(off.dz, IDX_W'(r_sxy));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_ord  <= '0;
        end else if (i_cmd.build_mask) begin
            r_mask <= n_mask;
            r_ord  <= '0;
        end else if (i_cmd.emit) begin
            r_mask <= rest;
            r_ord  <= r_ord + ORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_mask == '0) begin
                r_out_idx  <= '0;
                r_out_ord  <= '0;
                r_out_vld  <= 1'b0;
                r_out_last <= 1'b1;
            end else begin
                r_out_idx  <= nbr;
                r_out_ord  <= r_ord;
                r_out_vld  <= 1'b1;
                r_out_last <= (rest == '0);
            end
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.last_pick = (rest == '0);

    assign o_out_valid = r_out_valid;
    assign o_nbr_idx   = r_out_idx;
    assign o_nbr_ord   = r_out_ord;
    assign o_is_valid  = r_out_vld;
    assign o_is_last   = r_out_last;

endmodule

// ----- sv/gtne_ctrl.sv -----
// ----------------------------------------------------------------------------
// gtne_ctrl - sequencing state machine
// Takes one request, runs the two divisions, builds the neighbour mask and
// hands out one result per free output slot until the last one.
// ----------------------------------------------------------------------------
module gtne_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gtne_pkg::t_dp_sts i_sts,
    output gtne_pkg::t_dp_cmd o_cmd
);
    import gtne_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DIV1_GO = 7'b0000010,
        S_DIV1    = 7'b0000100,
        S_DIV2_GO = 7'b0001000,
        S_DIV2    = 7'b0010000,
        S_MASK    = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIV1_GO;
                end
            end
            S_DIV1_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.take_x = 1'b1;
                    n_state      = S_DIV2_GO;
                end
            end
            S_DIV2_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_sel = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.take_yz = 1'b1;
                    n_state       = S_MASK;
                end
            end
            S_MASK: begin
                o_cmd.build_mask = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pick) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/grid_tet_neighbor_enumerator.sv -----
// ----------------------------------------------------------------------------
// grid_tet_neighbor_enumerator - tetrahedral grid vertex neighbour enumerator
// After a request is taken, the bit-serial divider is used twice, with 30 steps
//   each, to decode x, y and z, and the neighbour mask is built; results then
//   follow at one per cycle while the output is free, 1 to 18 per request.
//   A new request is taken only after the last result of the previous one.
// Reset: synchronous, active low; sizes return to 1 and parity reference to 1.
// ----------------------------------------------------------------------------
module grid_tet_neighbor_enumerator #(
    parameter int unsigned AXIS_MAX = gtne_pkg::AXIS_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gtne_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [29:0] vertex_index
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gtne_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [29:0] neighbor_index,
                                                             // [34:30] neighbor_ordinal
    output logic                             m_axis_tuser,   // [0] is_valid
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gtne_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [gtne_pkg::CFG_W-1:0]       i_cfg_data
);
    import gtne_pkg::*;

    localparam int unsigned PAD_W = M_TDATA_W - IDX_W - ORD_W;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] nbr_idx;
    logic [ORD_W-1:0] nbr_ord;

    assign o_cfg_ready = 1'b1;

    gtne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gtne_datapath #(
        .AXIS_MAX (AXIS_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_vertex    (s_axis_tdata[IDX_W-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_nbr_idx   (nbr_idx),
        .o_nbr_ord   (nbr_ord),
        .o_is_valid  (m_axis_tuser),
        .o_is_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, nbr_ord, nbr_idx};

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one still in progress");

    a_busy_midrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("ready raised before final result of a run");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && nbr_ord == '0 && nbr_idx == '0))
        else $error("invalid result not a lone final zero result");

    a_ord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (nbr_ord < ORD_W'(NSLOT)))
        else $error("neighbour ordinal out of range");

endmodule
